// ----- src/bma_pkg.sv -----
`default_nettype none

package bma_pkg;

  localparam int unsigned AVG_W       = 12;
  localparam int unsigned WIN_W       = 9;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned WIN_RESET   = 200;

  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- src/boxcar_moving_average_unit.sv -----
// Boxcar moving-average unit.
// Input channel: sample_i with in_valid_i / in_ready_o. Output channel:
// average_o with out_valid_o / out_ready_i. A transfer happens on a rising
// edge with valid and ready both high.
// Each sample replaces the oldest slot of a circular window and the block
// returns the truncated mean of the window (window_size most recent
// samples, unwritten slots counting as zero).
// APB register 0 (byte address 0): window_size, 1..DEPTH; a write clears
// the window. Write it only while the block is idle.
// One item is in work at a time: the block takes a new sample only after
// the bit-serial divider, one quotient bit per cycle, has finished the
// item before it.
// The output register holds one result; the next sample is taken while
// it waits. If the receiver stalls, the finished result of the following
// item waits inside the block and in_ready_o stays low.
// Reset: window empty, window_size = 200 (capped at DEPTH), no result pending.
`default_nettype none

module boxcar_moving_average_unit #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [SAMPLE_BITS-1:0]           sample_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  output logic [bma_pkg::AVG_W-1:0]             average_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bma_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [bma_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bma_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  localparam int unsigned WW     = bma_pkg::WIN_W;
  localparam int unsigned PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(DEPTH);
  localparam int unsigned CMP_W  = (PW + 1 > WW) ? PW + 1 : WW;
  localparam int unsigned WIN_RST =
    (bma_pkg::WIN_RESET > DEPTH) ? DEPTH : bma_pkg::WIN_RESET;

  bma_pkg::state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [PW-1:0]          pos_q;
  logic [PW:0]            pos_inc;
  logic                   pos_wrap;
  logic                   wrapped_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [WW-1:0]          window_q;
  logic [WW-1:0]          win_legal;
  logic [bma_pkg::AVG_W-1:0] avg_q;
  logic                   out_valid_q;

  logic                   in_fire;
  logic                   cfg_we;
  logic                   do_update;
  logic                   load_out;
  logic                   div_done;
  logic [bma_pkg::AVG_W-1:0] div_quo;

  assign in_fire = in_valid_i & in_ready_o;
  assign cfg_we  = psel & penable & pwrite & (paddr[2] == bma_pkg::REG_WINDOW);
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == bma_pkg::REG_WINDOW) begin
      prdata[WW-1:0] = window_q;
    end
  end

  always_comb begin
    if (pwdata[WW-1:0] == '0) begin
      win_legal = WW'(1);
    end else if (32'(pwdata[WW-1:0]) > 32'(DEPTH)) begin
      win_legal = WW'(DEPTH);
    end else begin
      win_legal = pwdata[WW-1:0];
    end
  end

  // slots at or past the position are fresh until the first wrap
  assign old_val  = wrapped_q ? rd_q : '0;
  assign sum_d    = sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
  assign pos_inc  = {1'b0, pos_q} + (PW + 1)'(1);
  assign pos_wrap = (CMP_W'(pos_inc) >= CMP_W'(window_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    do_update  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      bma_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = bma_pkg::ST_UPDATE;
        end
      end
      bma_pkg::ST_UPDATE: begin
        do_update = 1'b1;
        state_d   = bma_pkg::ST_DIVIDE;
      end
      bma_pkg::ST_DIVIDE: begin
        if (div_done) begin
          if (!out_valid_q || out_ready_i) begin
            load_out = 1'b1;
            state_d  = bma_pkg::ST_IDLE;
          end else begin
            state_d = bma_pkg::ST_DONE;
          end
        end
      end
      bma_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = bma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WW'(WIN_RST);
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_q  <= win_legal;
        pos_q     <= '0;
        wrapped_q <= 1'b0;
        sum_q     <= '0;
      end else if (do_update) begin
        sum_q <= sum_d;
        if (pos_wrap) begin
          pos_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          pos_q <= pos_inc[PW-1:0];
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i;
      rd_q     <= mem_q[pos_q];
    end
    if (do_update) begin
      mem_q[pos_q] <= sample_q;
    end
    if (load_out) begin
      avg_q <= div_quo;
    end
  end

  bma_serial_div #(
    .NUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_update),
    .dividend_i (sum_d),
    .divisor_i  (window_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign average_o   = avg_q;
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(pos_q) < CMP_W'(window_q))
    else $error("write position outside window");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken while item in work");

  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == bma_pkg::ST_DIVIDE)
    else $error("divider finished outside divide state");

  a_wrap_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wrapped_q) |-> pos_q == '0)
    else $error("window wrap without position reset");
`endif

endmodule

`default_nettype wire

// ----- src/bma_serial_div.sv -----
`default_nettype none

module bma_serial_div #(
  parameter int unsigned NUM_W = 20
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [NUM_W-1:0]           dividend_i,
  input  wire logic [bma_pkg::WIN_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [bma_pkg::AVG_W-1:0]       quotient_o
);

  localparam int unsigned DW    = bma_pkg::WIN_W;
  localparam int unsigned QW    = bma_pkg::AVG_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DW-1:0]    div_q;
  logic [DW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      trial;
  logic             ge;

  // one restoring step per cycle, dividend shifted out msb first
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = (trial >= {1'b0, div_q});
    if (ge) begin
      rem_d = DW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
